/* rtl/tkef_pkg.sv */
// Shared types and constants for the top-K edge filter.
package tkef_pkg;

    localparam int SCORE_W       = 16;
    localparam int NODE_W        = 12;
    localparam int CMD_W         = 2;
    localparam int K_W           = 4;
    localparam int PADDR_W       = 5;
    localparam int PDATA_W       = 32;
    localparam int DEF_MAX_NODES = 4096;
    localparam int DEF_MAX_K     = 8;

    localparam logic signed [SCORE_W-1:0] ONE_Q12 = 16'sd4096;

    localparam logic [CMD_W-1:0] CMD_RANK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FILTER = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam logic [2:0] REG_MIN_FIRST_EN  = 3'd0;
    localparam logic [2:0] REG_MIN_FIRST     = 3'd1;
    localparam logic [2:0] REG_MIN_SECOND_EN = 3'd2;
    localparam logic [2:0] REG_MIN_SECOND    = 3'd3;
    localparam logic [2:0] REG_RANK_BOTH     = 3'd4;
    localparam logic [2:0] REG_RANK_EITHER   = 3'd5;
    localparam logic [2:0] REG_K_BOTH        = 3'd6;
    localparam logic [2:0] REG_K_EITHER      = 3'd7;

    typedef struct packed {
        logic                      min_first_enable;
        logic signed [SCORE_W-1:0] min_first_score;
        logic                      min_second_enable;
        logic signed [SCORE_W-1:0] min_second_score;
        logic                      rank_both_enable;
        logic                      rank_either_enable;
        logic [K_W-1:0]            k_for_both;
        logic [K_W-1:0]            k_for_either;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RANK_RD,
        ST_RANK_WA,
        ST_RANK_WB,
        ST_FILT_RD,
        ST_FILT_EV
    } state_t;

endpackage

/* rtl/tkef_row_mem.sv */
// Node row memory: one write port, two registered read ports.
module tkef_row_mem
    import tkef_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_NODES,
    parameter int AW    = $clog2(DEF_MAX_NODES),
    parameter int RW    = 132
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [RW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [RW-1:0] rdata_a,
    output logic [RW-1:0] rdata_b
);

    logic [RW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

/* rtl/tkef_row_update.sv */
// Inserts one score into a node row kept in descending order.
module tkef_row_update
    import tkef_pkg::*;
#(
    parameter int MAX_K = DEF_MAX_K
) (
    input  logic [$clog2(MAX_K+1)+MAX_K*SCORE_W-1:0] row_in,
    input  logic signed [SCORE_W-1:0]                score,
    output logic [$clog2(MAX_K+1)+MAX_K*SCORE_W-1:0] row_out
);

    localparam int CW = $clog2(MAX_K + 1);

    logic [CW-1:0] n;
    logic [MAX_K-1:0] hold;

    assign n = row_in[CW-1:0];
    assign row_out[CW-1:0] = (n == CW'(MAX_K)) ? n : n + CW'(1);

    // A lane holds its value when it is occupied and not below the new score.
    // The first lane that does not hold takes the score; later lanes shift down.
    for (genvar i = 0; i < MAX_K; i++)
    begin : g_lane
        logic signed [SCORE_W-1:0] old_v;
        logic prev_hold;
        assign old_v = row_in[CW+i*SCORE_W +: SCORE_W];
        assign hold[i] = (CW'(i) < n) && (old_v >= score);
        if (i == 0)
        begin : g_first
            assign prev_hold = 1'b1;
            assign row_out[CW +: SCORE_W] = hold[0] ? old_v : score;
        end
        else
        begin : g_rest
            assign prev_hold = hold[i-1];
            assign row_out[CW+i*SCORE_W +: SCORE_W] =
                hold[i] ? old_v :
                (prev_hold ? score : row_in[CW+(i-1)*SCORE_W +: SCORE_W]);
        end
    end

endmodule

/* rtl/tkef_cfg.sv */
// Configuration register file behind the APB-style port.
module tkef_cfg
    import tkef_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic [2:0] idx;

    assign idx    = paddr[PADDR_W-1:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            unique case (idx)
                REG_MIN_FIRST_EN:  cfg_next.min_first_enable   = pwdata[0];
                REG_MIN_FIRST:     cfg_next.min_first_score    = pwdata[SCORE_W-1:0];
                REG_MIN_SECOND_EN: cfg_next.min_second_enable  = pwdata[0];
                REG_MIN_SECOND:    cfg_next.min_second_score   = pwdata[SCORE_W-1:0];
                REG_RANK_BOTH:     cfg_next.rank_both_enable   = pwdata[0];
                REG_RANK_EITHER:   cfg_next.rank_either_enable = pwdata[0];
                REG_K_BOTH:        cfg_next.k_for_both         = pwdata[K_W-1:0];
                REG_K_EITHER:      cfg_next.k_for_either       = pwdata[K_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_MIN_FIRST_EN:  prdata = PDATA_W'(cfg_reg.min_first_enable);
            REG_MIN_FIRST:     prdata = PDATA_W'(cfg_reg.min_first_score);
            REG_MIN_SECOND_EN: prdata = PDATA_W'(cfg_reg.min_second_enable);
            REG_MIN_SECOND:    prdata = PDATA_W'(cfg_reg.min_second_score);
            REG_RANK_BOTH:     prdata = PDATA_W'(cfg_reg.rank_both_enable);
            REG_RANK_EITHER:   prdata = PDATA_W'(cfg_reg.rank_either_enable);
            REG_K_BOTH:        prdata = PDATA_W'(cfg_reg.k_for_both);
            REG_K_EITHER:      prdata = PDATA_W'(cfg_reg.k_for_either);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/topk_edge_filter_unit.sv */
// Top level of the per-node top-K edge filter.
// Items are accepted only in ST_IDLE, so each one is finished before the next is taken.
// A filter item reads both node rows; its keep flag is registered once the output is free.
// A rank item reads both rows, then writes node A's row, then node B's row, through
// the single write port of the row memory. Clear items and reset start a pass over
// the row memory that zeroes each node's count; no item is accepted until it finishes.
module topk_edge_filter_unit
    import tkef_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int MAX_K     = DEF_MAX_K
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [CMD_W-1:0]          cmd,
    input  logic [NODE_W-1:0]         node_a,
    input  logic [NODE_W-1:0]         node_b,
    input  logic signed [SCORE_W-1:0] first_score,
    input  logic signed [SCORE_W-1:0] second_score,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      keep,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [PDATA_W-1:0]        pwdata,
    output logic [PDATA_W-1:0]        prdata,
    output logic                      pready
);

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_K + 1);
    localparam int RW = CW + MAX_K * SCORE_W;

    cfg_t cfg;

    tkef_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The accepted item is held in these registers while it is worked on.
    logic [CMD_W-1:0]          cmd_reg;
    logic [NODE_W-1:0]         node_a_reg;
    logic [NODE_W-1:0]         node_b_reg;
    logic signed [SCORE_W-1:0] s1_reg;
    logic signed [SCORE_W-1:0] s2_reg;

    state_t state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic out_valid_reg, out_valid_next;
    logic keep_reg, keep_next;
    logic [RW-1:0] row_a_new_reg;

    logic accept;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign keep      = keep_reg;

    logic [AW-1:0] addr_a, addr_b;
    logic a_in_range, b_in_range;
    assign addr_a     = AW'(node_a_reg);
    assign addr_b     = AW'(node_b_reg);
    assign a_in_range = 32'(node_a_reg) < MAX_NODES;
    assign b_in_range = 32'(node_b_reg) < MAX_NODES;

    // Row memory: each node row holds its count and its kept scores.
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr;
    logic [RW-1:0] mem_wdata, rd_a, rd_b;

    tkef_row_mem #(
        .DEPTH (MAX_NODES),
        .AW    (AW),
        .RW    (RW)
    ) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .re      (mem_re),
        .raddr_a (addr_a),
        .raddr_b (addr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // Node B's row is forwarded from node A's update when both name the same node,
    // so a score inserted for the same node twice lands twice.
    logic [RW-1:0] row_b_src, upd_a, upd_b;
    assign row_b_src = (a_in_range && addr_a == addr_b) ? row_a_new_reg : rd_b;

    tkef_row_update #(.MAX_K(MAX_K)) u_upd_a (
        .row_in  (rd_a),
        .score   (s1_reg),
        .row_out (upd_a)
    );

    tkef_row_update #(.MAX_K(MAX_K)) u_upd_b (
        .row_in  (row_b_src),
        .score   (s1_reg),
        .row_out (upd_b)
    );

    // Cutoff of a node: its min(k, count)-th largest score, or 1.0 for none or for a node out of range.
    logic [K_W-1:0] k_raw;
    logic [CW-1:0]  k_eff;
    always_comb
    begin
        k_raw = '0;
        if (cfg.rank_both_enable)
        begin
            k_raw = cfg.k_for_both;
        end
        if (cfg.rank_either_enable)
        begin
            k_raw = cfg.k_for_either;
        end
        k_eff = (32'(k_raw) > MAX_K) ? CW'(MAX_K) : CW'(k_raw);
    end

    function automatic logic signed [SCORE_W-1:0] cutoff(
        input logic [RW-1:0] row,
        input logic          in_range,
        input logic [CW-1:0] k
    );
        logic [CW-1:0] n;
        logic signed [SCORE_W-1:0] v;
        n = row[CW-1:0];
        if (k < n)
        begin
            n = k;
        end
        v = ONE_Q12;
        for (int i = 0; i < MAX_K; i++)
        begin
            if (n == CW'(i + 1))
            begin
                v = row[CW+i*SCORE_W +: SCORE_W];
            end
        end
        if (!in_range)
        begin
            v = ONE_Q12;
        end
        return v;
    endfunction

    logic signed [SCORE_W-1:0] cut_a, cut_b;
    logic keep_eval;
    assign cut_a = cutoff(rd_a, a_in_range, k_eff);
    assign cut_b = cutoff(rd_b, b_in_range, k_eff);

    always_comb
    begin
        keep_eval = 1'b1;
        if (cfg.min_first_enable && cfg.min_first_score > s1_reg)
        begin
            keep_eval = 1'b0;
        end
        if (cfg.min_second_enable && cfg.min_second_score > s2_reg)
        begin
            keep_eval = 1'b0;
        end
        if (cfg.rank_both_enable && (cut_a > s1_reg || cut_b > s1_reg))
        begin
            keep_eval = 1'b0;
        end
        if (cfg.rank_either_enable && cut_a > s1_reg && cut_b > s1_reg)
        begin
            keep_eval = 1'b0;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && out_stall;
        keep_next      = keep_reg;
        in_stall       = 1'b1;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = addr_a;
        mem_wdata      = upd_a;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(MAX_NODES - 1))
                begin
                    clr_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    priority if (cmd == CMD_RANK)
                    begin
                        state_next = ST_RANK_RD;
                    end
                    else if (cmd == CMD_FILTER)
                    begin
                        state_next = ST_FILT_RD;
                    end
                    else if (cmd == CMD_CLEAR)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RANK_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_RANK_WA;
            end
            ST_RANK_WA:
            begin
                mem_we     = a_in_range;
                state_next = ST_RANK_WB;
            end
            ST_RANK_WB:
            begin
                mem_we     = b_in_range;
                mem_waddr  = addr_b;
                mem_wdata  = upd_b;
                state_next = ST_IDLE;
            end
            ST_FILT_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_FILT_EV;
            end
            ST_FILT_EV:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    keep_next      = keep_eval;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        keep_reg <= keep_next;
        if (accept)
        begin
            cmd_reg    <= cmd;
            node_a_reg <= node_a;
            node_b_reg <= node_b;
            s1_reg     <= first_score;
            s2_reg     <= second_score;
        end
        if (state_reg == ST_RANK_WA && cmd_reg == CMD_RANK)
        begin
            row_a_new_reg <= upd_a;
        end
    end

endmodule

/* bench/tkef_checker.sv */
// Checker for the top-K edge filter: tracks the register file, predicts keep flags, compares them.
module tkef_checker
    import tkef_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic [CMD_W-1:0]          cmd,
    input  logic [NODE_W-1:0]         node_a,
    input  logic [NODE_W-1:0]         node_b,
    input  logic signed [SCORE_W-1:0] first_score,
    input  logic signed [SCORE_W-1:0] second_score,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic                      keep,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [PDATA_W-1:0]        pwdata,
    input  logic                      pready,
    output int                        mismatches,
    output int                        keeps_pending
);

    localparam int NODES = DEF_MAX_NODES;
    localparam int KMAX  = DEF_MAX_K;

    cfg_t                      cfg;
    logic signed [SCORE_W-1:0] best_scores [NODES][KMAX];
    int                        kept_count  [NODES];
    logic                      keep_expected [$];

    // Inserts one score into a node's descending list of its largest scores.
    task automatic add_score(input int node, input logic signed [SCORE_W-1:0] s);
        int n;
        int pos;
        n = kept_count[node];
        if (n >= KMAX)
        begin
            if (s <= best_scores[node][KMAX-1])
                return;
            n = KMAX - 1;
        end
        else
            kept_count[node] = n + 1;
        pos = n;
        while (pos > 0 && best_scores[node][pos-1] < s)
        begin
            best_scores[node][pos] = best_scores[node][pos-1];
            pos--;
        end
        best_scores[node][pos] = s;
    endtask

    function automatic logic signed [SCORE_W-1:0] rank_cutoff(input int node, input int k);
        int n;
        n = kept_count[node];
        if (k < n)
            n = k;
        if (n == 0)
            return ONE_Q12;
        return best_scores[node][n-1];
    endfunction

    function automatic logic keep_for_edge(input int na, input int nb,
                                           input logic signed [SCORE_W-1:0] s1,
                                           input logic signed [SCORE_W-1:0] s2);
        int k;
        logic signed [SCORE_W-1:0] ca;
        logic signed [SCORE_W-1:0] cb;
        logic ok;
        k = 0;
        ok = 1'b1;
        if (cfg.rank_both_enable)
            k = int'(cfg.k_for_both);
        if (cfg.rank_either_enable)
            k = int'(cfg.k_for_either);
        if (k > KMAX)
            k = KMAX;
        ca = rank_cutoff(na, k);
        cb = rank_cutoff(nb, k);
        if (cfg.min_first_enable && cfg.min_first_score > s1)
            ok = 1'b0;
        if (cfg.min_second_enable && cfg.min_second_score > s2)
            ok = 1'b0;
        if (cfg.rank_both_enable && (ca > s1 || cb > s1))
            ok = 1'b0;
        if (cfg.rank_either_enable && ca > s1 && cb > s1)
            ok = 1'b0;
        return ok;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg = '0;
            mismatches = 0;
            keep_expected.delete();
            keeps_pending = 0;
            for (int i = 0; i < NODES; i++)
                kept_count[i] = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[PADDR_W-1:2])
                    REG_MIN_FIRST_EN:  cfg.min_first_enable   = pwdata[0];
                    REG_MIN_FIRST:     cfg.min_first_score    = pwdata[SCORE_W-1:0];
                    REG_MIN_SECOND_EN: cfg.min_second_enable  = pwdata[0];
                    REG_MIN_SECOND:    cfg.min_second_score   = pwdata[SCORE_W-1:0];
                    REG_RANK_BOTH:     cfg.rank_both_enable   = pwdata[0];
                    REG_RANK_EITHER:   cfg.rank_either_enable = pwdata[0];
                    REG_K_BOTH:        cfg.k_for_both         = pwdata[K_W-1:0];
                    REG_K_EITHER:      cfg.k_for_either       = pwdata[K_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                case (cmd)
                    CMD_RANK:
                    begin
                        add_score(int'(node_a), first_score);
                        add_score(int'(node_b), first_score);
                    end
                    CMD_FILTER:
                        keep_expected.insert(keep_expected.size(),
                            keep_for_edge(int'(node_a), int'(node_b),
                                          first_score, second_score));
                    CMD_CLEAR:
                        for (int i = 0; i < NODES; i++)
                            kept_count[i] = 0;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (keep_expected.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected keep flag %0b with none pending", keep);
                end
                else if (keep_expected[0] !== keep)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("keep mismatch: expected %0b, got %0b",
                                 keep_expected[0], keep);
                    void'(keep_expected.pop_front());
                end
                else
                    void'(keep_expected.pop_front());
            end
            keeps_pending = keep_expected.size();
        end
    end

endmodule

/* bench/tb_top.sv */
// Top of the top-K edge filter testbench: stimulus, register setup and the verdict.
module tb_top;
    import tkef_pkg::*;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic [CMD_W-1:0]          cmd;
    logic [NODE_W-1:0]         node_a;
    logic [NODE_W-1:0]         node_b;
    logic signed [SCORE_W-1:0] first_score;
    logic signed [SCORE_W-1:0] second_score;
    logic                      out_valid;
    logic                      out_stall;
    logic                      keep;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [PADDR_W-1:0]        paddr;
    logic [PDATA_W-1:0]        pwdata;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;

    int mismatches;
    int keeps_pending;

    // When quiet is set neither side inserts idle cycles, giving back-to-back traffic.
    // hold_results asks the result side for one long stall.
    bit quiet;
    bit hold_results;
    int idle_cycles;

    // A clear pass takes one cycle per node, so the watchdog allows well over that.
    localparam int WATCHDOG_LIMIT = 20000;
    // Filter items return a keep flag after a row read; rank items write two rows after acceptance.
    localparam int SETTLE_CYCLES  = 12;

    topk_edge_filter_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .node_a(node_a), .node_b(node_b),
        .first_score(first_score), .second_score(second_score),
        .out_valid(out_valid), .out_stall(out_stall), .keep(keep),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    tkef_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .node_a(node_a), .node_b(node_b),
        .first_score(first_score), .second_score(second_score),
        .out_valid(out_valid), .out_stall(out_stall), .keep(keep),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .mismatches(mismatches), .keeps_pending(keeps_pending)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // The watchdog counts cycles in which neither channel nor the register port moves.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: a random stall before each result, and one long hold on request
    // so that the block backs up into its input.
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_results)
            begin
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                hold_results = 1'b0;
            end
            n = quiet ? 0 : $urandom_range(0, 10);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    // Sends one item after a random gap and returns at the edge where it is taken.
    // The valid stays high into the next call, which lowers it only if it idles.
    task automatic send_item(input logic [CMD_W-1:0] c, input logic [NODE_W-1:0] a,
                             input logic [NODE_W-1:0] b,
                             input logic signed [SCORE_W-1:0] s1,
                             input logic signed [SCORE_W-1:0] s2);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        cmd          <= c;
        node_a       <= a;
        node_b       <= b;
        first_score  <= s1;
        second_score <= s2;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_all(input logic fe, input logic [15:0] fs, input logic se,
                             input logic [15:0] ss, input logic both,
                             input logic either, input logic [3:0] kb,
                             input logic [3:0] ke);
        write_reg(REG_MIN_FIRST_EN, PDATA_W'(fe));
        write_reg(REG_MIN_FIRST, PDATA_W'(fs));
        write_reg(REG_MIN_SECOND_EN, PDATA_W'(se));
        write_reg(REG_MIN_SECOND, PDATA_W'(ss));
        write_reg(REG_RANK_BOTH, PDATA_W'(both));
        write_reg(REG_RANK_EITHER, PDATA_W'(either));
        write_reg(REG_K_BOTH, PDATA_W'(kb));
        write_reg(REG_K_EITHER, PDATA_W'(ke));
    endtask

    // Ends a phase: a final filter item so the block cannot be mid-clear, then the
    // sender pauses until every keep flag is back and the row writes have settled.
    // The pending count is first looked at on the edge after the one where the item was taken.
    task automatic drain();
        send_item(CMD_FILTER, 12'd0, 12'd1, 16'sd0, 16'sd0);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (keeps_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [NODE_W-1:0] pick_node();
        if ($urandom_range(0, 99) < 85)
            return NODE_W'($urandom_range(0, 7));
        return NODE_W'($urandom);
    endfunction

    // Half the scores come from a few values near the cutoffs so ties happen often.
    function automatic logic [SCORE_W-1:0] pick_score();
        case ($urandom_range(0, 7))
            0: return 16'h1000;
            1: return 16'h0000;
            2: return 16'h0800;
            3: return 16'hF000;
            default: return SCORE_W'($urandom);
        endcase
    endfunction

    task automatic random_items(input int count);
        int r;
        logic [CMD_W-1:0] c;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 199);
            if (r < 2)
                c = CMD_CLEAR;
            else if (r < 10)
                c = CMD_UNUSED;
            else if (r < 100)
                c = CMD_RANK;
            else
                c = CMD_FILTER;
            send_item(c, pick_node(), pick_node(), pick_score(), pick_score());
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        cmd          = CMD_RANK;
        node_a       = '0;
        node_b       = '0;
        first_score  = '0;
        second_score = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        quiet        = 1'b1;
        hold_results = 1'b0;
        idle_cycles  = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: both-mode with a small k and the score minimums at their extremes.
        write_all(1'b1, 16'h8000, 1'b1, 16'h8000, 1'b1, 1'b0, 4'd2, 4'd0);
        // Empty nodes use the 1.0 cutoff: a score equal to it passes, one below fails.
        send_item(CMD_FILTER, 12'd5, 12'd6, 16'sd4096, 16'sd0);
        send_item(CMD_FILTER, 12'd5, 12'd6, 16'sd4095, 16'sd0);
        // The same node on both ends inserts the score twice.
        send_item(CMD_RANK, 12'd3, 12'd3, 16'sd100, 16'sd0);
        send_item(CMD_FILTER, 12'd3, 12'd3, 16'sd100, 16'sd0);
        send_item(CMD_FILTER, 12'd3, 12'd3, 16'sd99, 16'sd0);
        // Fill node 4095 past eight entries, with ties against the smallest kept score.
        for (int i = 0; i < 10; i++)
            send_item(CMD_RANK, 12'd4095, 12'd0, (i < 5) ? 16'sh7FFF : 16'sh8000, 16'sh7FFF);
        send_item(CMD_FILTER, 12'd4095, 12'd0, 16'sh7FFF, 16'sh7FFF);
        send_item(CMD_FILTER, 12'd4095, 12'd0, 16'sh8000, 16'sh8000);
        // An unused command does nothing, and a clear empties every list.
        send_item(CMD_UNUSED, 12'd4095, 12'd4095, 16'sh7FFF, 16'sh7FFF);
        send_item(CMD_CLEAR, 12'd0, 12'd0, 16'sd0, 16'sd0);
        send_item(CMD_FILTER, 12'd4095, 12'd3, 16'sh7FFF, 16'sd0);
        drain();

        // Random phases, each under its own register setting.
        write_all(1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0, 1'b1, 4'd0, 4'd3);
        random_items(150);
        drain();
        quiet = 1'b0;

        write_all(1'b1, 16'h7FFF, 1'b0, 16'h8000, 1'b1, 1'b0, 4'd8, 4'd15);
        random_items(150);
        drain();

        write_all(1'b1, 16'h0000, 1'b1, 16'hF000, 1'b1, 1'b1, 4'd15, 4'd8);
        random_items(150);
        // Hold results back for a long stretch while items keep coming in.
        hold_results = 1'b1;
        for (int i = 0; i < 40; i++)
            send_item(CMD_FILTER, pick_node(), pick_node(), pick_score(), pick_score());
        drain();

        write_all(1'b0, 16'hFFFF, 1'b1, 16'h0800, 1'b1, 1'b0, 4'd1, 4'd0);
        random_items(200);
        drain();

        for (int p = 0; p < 3; p++)
        begin
            write_all(1'($urandom_range(0, 1)), 16'($urandom), 1'($urandom_range(0, 1)),
                      16'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
            quiet = (p == 1);
            random_items(150);
            drain();
        end

        if (mismatches == 0 && keeps_pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
